@@ src/brfc_pkg.sv @@
// shared types, sizes and codes of the chunked circular byte fifo
package brfc_pkg;

  // storage size and chunk limit
  localparam int CAPACITY  = 1024;
  localparam int MAX_CHUNK = 64;

  // widths derived from the sizes
  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LEN_W = 7;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // command codes carried in func
  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NONE = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_BUSY   = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    CS_IDLE,
    CS_READ
  } ctl_state_e;

  // operation handed from the controller to the datapath
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ENQ,
    OP_BUSY,
    OP_REJECT,
    OP_ZERO,
    OP_READ
  } op_e;

  // input word
  typedef struct packed {
    func_e            func;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    status_e          status;
    logic [7:0]       read_byte;
    logic [LEN_W-1:0] count;
    logic             last;
  } res_word_t;

  // controller to datapath commands
  typedef struct packed {
    op_e  op;
    logic step;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic run_active;
    logic len_zero;
    logic data_short;
    logic step_last;
  } dp_stat_t;

  // next position around the ring
  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    wrap_next = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  // chunk length saturated at the chunk limit
  function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] v);
    cap_len = (v > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : v;
  endfunction

endpackage

@@ src/brfc_ram.sv @@
// generic single write port, single read port ram with registered read
module brfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/brfc_ctrl.sv @@
// controller state machine: sorts commands and sequences chunk reads
module brfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  brfc_pkg::func_e   func_i,
  input  brfc_pkg::dp_stat_t stat_i,
  output brfc_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);
  import brfc_pkg::*;

  ctl_state_e state_q, state_d;
  op_e        accept_op;

  // decode of an accepted word
  always_comb begin
    accept_op = OP_IDLE;
    case (func_i)
      FN_ENQ:  accept_op = OP_ENQ;
      FN_DEQ,
      FN_PEEK: begin
        if (stat_i.run_active) begin
          accept_op = OP_BUSY;
        end else if (stat_i.data_short) begin
          accept_op = OP_REJECT;
        end else if (stat_i.len_zero) begin
          accept_op = OP_ZERO;
        end else begin
          accept_op = OP_READ;
        end
      end
      default: accept_op = OP_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (start_i && accept_op == OP_READ) begin
          state_d = CS_READ;
        end
      end
      CS_READ: begin
        if (stat_i.step_last) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = OP_IDLE;
    cmd_o.step = 1'b0;
    busy_o     = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          cmd_o.op = accept_op;
        end
      end
      CS_READ: begin
        cmd_o.step = 1'b1;
        busy_o     = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/brfc_dp.sv @@
// datapath: pointers, space count, enqueue run tracking, byte store, result register
module brfc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brfc_pkg::in_word_t  in_i,
  input  brfc_pkg::dp_cmd_t   cmd_i,
  output brfc_pkg::dp_stat_t  stat_o,
  output logic                res_valid_o,
  output brfc_pkg::res_word_t res_o
);
  import brfc_pkg::*;

  // architectural state
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [LEN_W-1:0] run_rem_q, run_rem_d;
  logic             drop_q, drop_d;
  logic [LEN_W-1:0] run_len_q, run_len_d;

  // chunk read walk
  logic [PTR_W-1:0] walk_q, walk_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic             deq_q, deq_d;

  // result register
  logic             valid_q, valid_d;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             last_q, last_d;
  logic             sel_q, sel_d;

  // helpers
  logic [LEN_W-1:0] len_cap;
  logic [CMP_W-1:0] used;
  logic             first;
  logic [LEN_W-1:0] eff_rem;
  logic [LEN_W-1:0] eff_len;
  logic             eff_drop;
  logic             ram_we;
  logic [7:0]       ram_rdata;

  assign len_cap = cap_len(in_i.length);
  assign used    = CMP_W'(CAPACITY) - CMP_W'(free_q);
  assign first   = (run_rem_q == '0);

  // status to the controller
  assign stat_o.run_active = !first;
  assign stat_o.len_zero   = (len_cap == '0);
  assign stat_o.data_short = (used < CMP_W'(len_cap));
  assign stat_o.step_last  = (k_q == LEN_W'(len_q - 1'b1));

  // enqueue run view for this word
  always_comb begin
    if (first) begin
      eff_rem  = len_cap;
      eff_len  = len_cap;
      eff_drop = (CMP_W'(free_q) < CMP_W'(len_cap));
    end else begin
      eff_rem  = run_rem_q;
      eff_len  = run_len_q;
      eff_drop = drop_q;
    end
  end

  assign ram_we = (cmd_i.op == OP_ENQ) && !eff_drop && (eff_rem != '0);

  // next state and result
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    free_d    = free_q;
    run_rem_d = run_rem_q;
    drop_d    = drop_q;
    run_len_d = run_len_q;
    walk_d    = walk_q;
    len_d     = len_q;
    k_d       = k_q;
    deq_d     = deq_q;
    valid_d   = 1'b0;
    status_d  = ST_OK;
    count_d   = '0;
    last_d    = 1'b1;
    sel_d     = 1'b0;
    case (cmd_i.op)
      OP_ENQ: begin
        if (eff_rem == '0) begin
          // zero-length run is complete in one word
          valid_d = 1'b1;
        end else begin
          run_len_d = eff_len;
          run_rem_d = LEN_W'(eff_rem - 1'b1);
          drop_d    = eff_drop;
          if (!eff_drop) begin
            wr_ptr_d = wrap_next(wr_ptr_q);
            free_d   = CNT_W'(free_q - 1'b1);
          end
          if (eff_rem == LEN_W'(1)) begin
            valid_d = 1'b1;
            drop_d  = 1'b0;
            if (eff_drop) begin
              status_d = ST_REJECT;
            end else begin
              count_d = eff_len;
            end
          end
        end
      end
      OP_BUSY: begin
        valid_d  = 1'b1;
        status_d = ST_BUSY;
      end
      OP_REJECT: begin
        valid_d  = 1'b1;
        status_d = ST_REJECT;
      end
      OP_ZERO: begin
        valid_d = 1'b1;
      end
      OP_READ: begin
        walk_d = rd_ptr_q;
        len_d  = len_cap;
        k_d    = '0;
        deq_d  = (in_i.func == FN_DEQ);
        if (in_i.func == FN_DEQ) begin
          free_d = CNT_W'(CMP_W'(free_q) + CMP_W'(len_cap));
        end
      end
      default: valid_d = 1'b0;
    endcase

    // one byte read per step
    if (cmd_i.step) begin
      walk_d  = wrap_next(walk_q);
      k_d     = LEN_W'(k_q + 1'b1);
      valid_d = 1'b1;
      count_d = len_q;
      last_d  = stat_o.step_last;
      sel_d   = 1'b1;
      if (stat_o.step_last && deq_q) begin
        rd_ptr_d = wrap_next(walk_q);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      free_q    <= CNT_W'(CAPACITY);
      run_rem_q <= '0;
      drop_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      free_q    <= free_d;
      run_rem_q <= run_rem_d;
      drop_q    <= drop_d;
      valid_q   <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    run_len_q <= run_len_d;
    walk_q    <= walk_d;
    len_q     <= len_d;
    k_q       <= k_d;
    deq_q     <= deq_d;
    status_q  <= status_d;
    count_q   <= count_d;
    last_q    <= last_d;
    sel_q     <= sel_d;
  end

  // byte store
  brfc_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_i.data_byte),
    .re_i    (cmd_i.step),
    .raddr_i (walk_q),
    .rdata_o (ram_rdata)
  );

  // result word
  assign res_valid_o     = valid_q;
  assign res_o.status    = status_q;
  assign res_o.read_byte = sel_q ? ram_rdata : 8'd0;
  assign res_o.count     = count_q;
  assign res_o.last      = last_q;

endmodule

@@ src/byte_ring_fifo_chunked.sv @@
// top level of the chunked circular byte fifo
//
//  channel   signals                        direction  handshake
//  command   start_i, in_i, busy_o          in         taken when start_i && !busy_o
//  result    res_valid_o, res_o             out        one-cycle strobe, no backpressure
//
// An enqueue byte's result, if any, shows in the next cycle.
// A dequeue or peek of n bytes holds busy_o in the read state while the
// controller steps through the chunk, and gives its bytes back to back, one byte
// per cycle through the single read port of the byte store. Busy, rejected and
// zero-length results come in the cycle after the command. Reset clears pointers,
// space count and run state; store contents are undefined until written.
// The receiver cannot stall the result strobe.
module byte_ring_fifo_chunked (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  brfc_pkg::in_word_t  in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output brfc_pkg::res_word_t res_o
);
  import brfc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  brfc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (in_i.func),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath
  brfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // every read cycle yields a result word in the next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> res_valid_o)
    else $error("read step without result word");

  // end of a chunk read lands on its last byte
  a_read_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (res_valid_o && res_o.last))
    else $error("chunk read ended without last word");

  // non-ok results are single, empty words
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |->
      (res_o.last && res_o.count == '0 && res_o.read_byte == 8'd0))
    else $error("failed result carries data");
`endif

endmodule
